/* rtl/increasing_subsequence_counter_defines.svh */
// ----------------------------------------------------------------------------
// Increasing subsequence counter: assertion macros
// Shared property macros for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef INCREASING_SUBSEQUENCE_COUNTER_DEFINES_SVH
`define INCREASING_SUBSEQUENCE_COUNTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define ISC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define ISC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/isc_pkg.sv */
// ----------------------------------------------------------------------------
// isc_pkg
// Widths and shared types of the increasing subsequence counter.
// ----------------------------------------------------------------------------
package isc_pkg;

	// field widths
	localparam int unsigned VAL_W = 32;
	localparam int unsigned CNT_W = 30;
	localparam int unsigned K_W   = 6;

	// reset value of the subsequence length register
	localparam logic [K_W-1:0] K_RESET = 6'd2;

	// controls from the sequencer to the lane accumulators
	typedef struct packed {
		logic acc_clr;  // clear the per-length sums (new request)
		logic acc_en;   // a stored row is on the read port
		logic col_clr;  // sequence restarts: drop column totals
		logic col_add;  // new row is written: add it to the totals
	} ctl_t;

endpackage

/* rtl/isc_mem.sv */
// ----------------------------------------------------------------------------
// isc_mem
// Single-port-write, single-port-read memory with a registered read.
// ----------------------------------------------------------------------------
module isc_mem #(
	parameter int unsigned DEPTH = 32,
	parameter int unsigned WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/isc_lanes.sv */
// ----------------------------------------------------------------------------
// isc_lanes
// One accumulator lane per subsequence length. Builds the row of a new
// element from the rows of smaller stored elements, and keeps per-length
// column totals over the whole sequence.
// ----------------------------------------------------------------------------
module isc_lanes #(
	parameter int unsigned MAX_ITEMS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  isc_pkg::ctl_t                     ctl,
	input  logic [isc_pkg::VAL_W-1:0]         v,
	input  logic [isc_pkg::VAL_W-1:0]         rd_value,
	input  logic [MAX_ITEMS*isc_pkg::CNT_W-1:0] rd_row,
	input  logic [isc_pkg::K_W-1:0]           k,
	output logic [MAX_ITEMS*isc_pkg::CNT_W-1:0] new_row,
	output logic [isc_pkg::CNT_W-1:0]         sel_total
);

	localparam int unsigned AW = $clog2(MAX_ITEMS);
	localparam int unsigned CW = isc_pkg::CNT_W;

	logic [CW-1:0]               acc_q    [1:MAX_ITEMS-1];
	logic [CW-1:0]               colsum_q [MAX_ITEMS];
	logic                        smaller;
	logic [isc_pkg::K_W-1:0]     km1;

	// stored element counts only when strictly below the new one
	assign smaller = $signed(rd_value) < $signed(v);

	// length L gathers the length L-1 counts of smaller elements
	always_ff @(posedge clk) begin
		if (ctl.acc_clr) begin
			for (int l = 1; l < MAX_ITEMS; l++) begin
				acc_q[l] <= '0;
			end
		end else if (ctl.acc_en && smaller) begin
			for (int l = 1; l < MAX_ITEMS; l++) begin
				acc_q[l] <= acc_q[l] + rd_row[(l-1)*CW +: CW];
			end
		end
	end

	// new row: one subsequence of length one, the sums above for the rest
	always_comb begin
		new_row[0 +: CW] = CW'(1);
		for (int l = 1; l < MAX_ITEMS; l++) begin
			new_row[l*CW +: CW] = acc_q[l];
		end
	end

	// column totals over all stored elements, modulo 2^30
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < MAX_ITEMS; l++) begin
				colsum_q[l] <= '0;
			end
		end else if (ctl.col_clr) begin
			for (int l = 0; l < MAX_ITEMS; l++) begin
				colsum_q[l] <= '0;
			end
		end else if (ctl.col_add) begin
			for (int l = 0; l < MAX_ITEMS; l++) begin
				colsum_q[l] <= colsum_q[l] + new_row[l*CW +: CW];
			end
		end
	end

	// pick the total for the current length; empty subsequence counts once
	assign km1 = k - isc_pkg::K_W'(1);

	always_comb begin
		sel_total = '0;
		if (k == '0) begin
			sel_total = CW'(1);
		end else if (k <= isc_pkg::K_W'(MAX_ITEMS)) begin
			sel_total = colsum_q[km1[AW-1:0]];
		end
	end

endmodule

/* rtl/isc_ctrl.sv */
// ----------------------------------------------------------------------------
// isc_ctrl
// Sequencer: takes a request, scans the stored rows one per cycle, writes
// the new row back and holds the result register.
// ----------------------------------------------------------------------------
`include "increasing_subsequence_counter_defines.svh"

module isc_ctrl #(
	parameter int unsigned MAX_ITEMS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [isc_pkg::VAL_W-1:0]     value,
	input  logic                          first,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [isc_pkg::CNT_W-1:0]     count,
	output logic                          overflow,
	// datapath
	input  logic [isc_pkg::CNT_W-1:0]     sel_total,
	output isc_pkg::ctl_t                 ctl,
	output logic [isc_pkg::VAL_W-1:0]     v,
	output logic                          rd_en,
	output logic [$clog2(MAX_ITEMS)-1:0]  rd_addr,
	output logic                          wr_en,
	output logic [$clog2(MAX_ITEMS)-1:0]  wr_addr
);

	localparam int unsigned AW = $clog2(MAX_ITEMS);
	localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_WRITE,
		S_DONE
	} state_t;

	state_t                        state_q;
	logic [CW-1:0]                 cnt_q;
	logic [CW-1:0]                 e_q;
	logic [AW-1:0]                 idx_q;
	logic                          ovf_q;
	logic                          rd_v_s1;
	logic [isc_pkg::VAL_W-1:0]     v_q;
	logic                          out_valid_q;
	logic [isc_pkg::CNT_W-1:0]     count_q;
	logic                          overflow_q;
	logic                          accept;
	logic                          full;
	logic                          out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign full      = !first && (cnt_q == CW'(MAX_ITEMS));
	assign out_free  = !out_valid_q || out_ready;

	// memory controls
	assign rd_en   = (state_q == S_SCAN);
	assign rd_addr = idx_q;
	assign wr_en   = (state_q == S_WRITE);
	assign wr_addr = e_q[AW-1:0];

	// lane controls
	always_comb begin
		ctl.acc_clr = accept;
		ctl.acc_en  = rd_v_s1;
		ctl.col_clr = accept && first;
		ctl.col_add = wr_en;
	end

	assign v         = v_q;
	assign out_valid = out_valid_q;
	assign count     = count_q;
	assign overflow  = overflow_q;

	// state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			e_q         <= '0;
			idx_q       <= '0;
			ovf_q       <= 1'b0;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			v_q         <= '0;
			count_q     <= '0;
			overflow_q  <= 1'b0;
		end else begin
			rd_v_s1 <= rd_en;
			// in S_DONE the result load below decides out_valid
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						v_q   <= value;
						ovf_q <= full;
						idx_q <= '0;
						e_q   <= first ? '0 : cnt_q;
						if (full) begin
							state_q <= S_DONE;
						end else if (first || cnt_q == '0) begin
							state_q <= S_WRITE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// one stored row per cycle, elements 0 .. e-1
					idx_q <= idx_q + AW'(1);
					if (CW'(idx_q) == e_q - CW'(1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					// last row lands in the lanes
					state_q <= S_WRITE;
				end
				S_WRITE: begin
					cnt_q   <= e_q + CW'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						count_q     <= sel_total;
						overflow_q  <= ovf_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// checks
	`ISC_ASSERT_NOW(a_cnt_max, 1'b1, cnt_q <= CW'(MAX_ITEMS), "element count past capacity")
	`ISC_ASSERT_NOW(a_scan_idx, state_q == S_SCAN, CW'(idx_q) < e_q, "scan beyond new element")
	`ISC_ASSERT_NEXT(a_cnt_adv, state_q == S_WRITE, cnt_q == $past(e_q) + CW'(1),
		"element count not advanced after row write")
	`ISC_ASSERT_NOW(a_ovf_full, state_q == S_DONE && ovf_q, cnt_q == CW'(MAX_ITEMS),
		"overflow reported while store not full")

endmodule

/* rtl/increasing_subsequence_counter.sv */
// ----------------------------------------------------------------------------
// increasing_subsequence_counter
// Counts strictly increasing subsequences of length k in a value stream.
// ----------------------------------------------------------------------------
// Usage:
//   Requests come in on in_valid/in_ready with a signed 32-bit value and a
//   first flag that restarts the sequence. Each request yields one result on
//   out_valid/out_ready: count, the number of strictly increasing
//   subsequences of k = subseq_length elements (mod 2^30), and overflow,
//   set when the store already held MAX_ITEMS elements and the value was
//   dropped.
//   The subseq_length register (APB, address 0, reset 2) is to be written
//   only while the block is idle, which the block itself does not enforce;
//   the count always follows its current value. A request landing as
//   element e scans e stored rows, drains the last read, writes its row and
//   loads the result (no scan or drain when e is 0; a full store only loads
//   the result). The scan reads one stored row of per-length counts a cycle
//   from the row memory, so that port sets the rate: one request at a time.
//   in_ready is high while the sequencer is idle; a finished result waits in
//   the output register, and the next request can be accepted meanwhile.
//   A stalled receiver holds the block before the result is loaded.
//   Reset empties the sequence and sets subseq_length to 2.
// ----------------------------------------------------------------------------
module increasing_subsequence_counter #(
	parameter int unsigned MAX_ITEMS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// request channel
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [isc_pkg::VAL_W-1:0] value,
	input  logic                      first,
	// result channel
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [isc_pkg::CNT_W-1:0] count,
	output logic                      overflow,
	// configuration
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [2:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);

	localparam int unsigned AW    = $clog2(MAX_ITEMS);
	localparam int unsigned ROW_W = MAX_ITEMS * isc_pkg::CNT_W;

	// register index within the APB window
	localparam logic [0:0] REG_SUBSEQ_LENGTH = 1'b0;

	logic [isc_pkg::K_W-1:0]   k_q;
	logic                      reg_wr;
	isc_pkg::ctl_t             ctl;
	logic [isc_pkg::VAL_W-1:0] v;
	logic                      rd_en;
	logic [AW-1:0]             rd_addr;
	logic                      wr_en;
	logic [AW-1:0]             wr_addr;
	logic [isc_pkg::VAL_W-1:0] rd_value;
	logic [ROW_W-1:0]          rd_row;
	logic [ROW_W-1:0]          new_row;
	logic [isc_pkg::CNT_W-1:0] sel_total;

	// APB register access
	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= isc_pkg::K_RESET;
		end else if (reg_wr && paddr[2] == REG_SUBSEQ_LENGTH) begin
			k_q <= pwdata[isc_pkg::K_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_SUBSEQ_LENGTH) begin
			prdata = 32'(k_q);
		end
	end

	// sequencer
	isc_ctrl #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.first     (first),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.count     (count),
		.overflow  (overflow),
		.sel_total (sel_total),
		.ctl       (ctl),
		.v         (v),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr)
	);

	// stored element values
	isc_mem #(
		.DEPTH(MAX_ITEMS),
		.WIDTH(isc_pkg::VAL_W)
	) u_value_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (v),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_value)
	);

	// per-element rows of ending counts, one lane per length
	isc_mem #(
		.DEPTH(MAX_ITEMS),
		.WIDTH(ROW_W)
	) u_row_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (new_row),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_row)
	);

	// lane accumulators and column totals
	isc_lanes #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_lanes (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.v         (v),
		.rd_value  (rd_value),
		.rd_row    (rd_row),
		.k         (k_q),
		.new_row   (new_row),
		.sel_total (sel_total)
	);

endmodule
